/* rtl/mma_pkg.sv */
// Shared types, constants and helpers for the MIDI message assembler.
package mma_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int BUF_DEPTH_MAX = 64;
  localparam int CMD_IDX_W     = $clog2(BUF_DEPTH_MAX);

  localparam logic [7:0] MIDI_SYSEX   = 8'hF0;
  localparam logic [7:0] MIDI_EOX     = 8'hF7;
  localparam logic [7:0] MASK_STATUS  = 8'h80;
  localparam logic [7:0] MASK_F1_F3   = 8'hFD;
  localparam logic [7:0] CODE_F1_F3   = 8'hF1;
  localparam logic [7:0] MASK_CX_DX   = 8'hE0;
  localparam logic [7:0] CODE_CX_DX   = 8'hC0;
  localparam logic [7:0] MASK_SYSTEM  = 8'hF0;

  // Work request handed from the parser to the message buffer.
  typedef struct packed {
    logic [7:0]           data;
    logic [CMD_IDX_W-1:0] idx;
    logic                 done;
  } cmd_t;

  // Total message length (status included) implied by a status byte.
  function automatic logic [1:0] needed_len(input logic [7:0] head);
    logic [1:0] len;
    if ((head & MASK_F1_F3) == CODE_F1_F3 || (head & MASK_CX_DX) == CODE_CX_DX) begin
      len = 2'd2;
    end else if ((head & MASK_SYSTEM) == MASK_SYSTEM) begin
      len = 2'd1;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

endpackage

/* rtl/mma_front.sv */
// Byte parser: running status, message framing and buffer slot assignment.
module mma_front
  import mma_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_midi_byte,
  input  logic       q_full,
  output logic       cmd_push,
  output cmd_t       cmd
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [7:0]  status_r;
  logic [AW-1:0] fill_r;

  logic [7:0]  status_nxt;
  logic [AW-1:0] fill_nxt;
  logic [AW-1:0] slot;
  logic [AW:0]   slot_inc;
  logic          keep;
  logic          done;
  logic          accept;
  logic          is_status;

  assign accept    = in_push && !q_full;
  assign is_status = (in_midi_byte & MASK_STATUS) != 8'h00;

  always_comb begin
    slot = fill_r;
    keep = 1'b1;
    if (fill_r == AW'(BUF_DEPTH - 1) && in_midi_byte != MIDI_EOX) begin
      keep = 1'b0;
    end else if (fill_r != '0 && is_status) begin
      // a new status aborts the partial message, except EOX closing a sysex block
      if (!(status_r == MIDI_SYSEX && in_midi_byte == MIDI_EOX)) begin
        slot = '0;
      end
    end else if (fill_r == '0 && !is_status) begin
      if ((status_r & MASK_STATUS) != 8'h00) begin
        slot = AW'(1);
      end else begin
        keep = 1'b0;
      end
    end
    status_nxt = (slot == '0) ? in_midi_byte : status_r;
    slot_inc   = {1'b0, slot} + (AW+1)'(1);
    if (status_nxt == MIDI_SYSEX) begin
      done = (in_midi_byte == MIDI_EOX);
    end else begin
      done = (slot_inc == (AW+1)'(needed_len(status_nxt)));
    end
    fill_nxt = done ? '0 : slot_inc[AW-1:0];
  end

  assign cmd_push = accept && keep;
  assign cmd.data = in_midi_byte;
  assign cmd.idx  = CMD_IDX_W'(slot);
  assign cmd.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      fill_r   <= '0;
    end else if (cmd_push) begin
      status_r <= status_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

/* rtl/mma_cmd_fifo.sv */
// Two-entry request queue between the parser and the message buffer.
module mma_cmd_fifo
  import mma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/mma_back.sv */
// Message buffer: stores parsed bytes and drains completed messages.
module mma_back
  import mma_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_message_byte,
  output logic       out_last_of_message
);

  localparam int AW = $clog2(BUF_DEPTH);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t        state_r;
  logic [7:0]    msg_mem [BUF_DEPTH];
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] last_r;
  logic          out_v_r;
  logic          out_last_r;
  logic [7:0]    out_byte_r;
  logic          load;
  logic          taken;

  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign taken  = out_pop && out_v_r;
  assign load   = (state_r == S_DRAIN) && (!out_v_r || out_pop);

  assign out_empty           = !out_v_r;
  assign out_message_byte    = out_byte_r;
  assign out_last_of_message = out_last_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      msg_mem[cmd.idx[AW-1:0]] <= cmd.data;
    end
    if (load) begin
      out_byte_r <= msg_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_ptr_r   <= '0;
      last_r     <= '0;
      out_v_r    <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop && cmd.done) begin
            last_r   <= cmd.idx[AW-1:0];
            rd_ptr_r <= '0;
            state_r  <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load) begin
            rd_ptr_r <= rd_ptr_r + AW'(1);
            if (rd_ptr_r == last_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (load) begin
        out_v_r    <= 1'b1;
        out_last_r <= (rd_ptr_r == last_r);
      end else if (taken) begin
        out_v_r <= 1'b0;
      end
    end
  end

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (rd_ptr_r <= last_r))
    else $error("drain pointer ran past message end");

  a_len_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) && $past(state_r == S_DRAIN) |-> $stable(last_r))
    else $error("message length changed during drain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    load && (rd_ptr_r == last_r) |=> (state_r == S_IDLE) && out_last_r)
    else $error("final byte did not close the drain");

endmodule

/* rtl/midi_message_assembler.sv */
// MIDI message assembler top level: parser, request queue and message buffer.
//
// Usage: one MIDI byte per request on the input queue (in_push / in_full);
// completed messages come out one byte per request on the result queue
// (out_empty / out_pop), in order, with out_last_of_message on the final byte.
// Running status, sysex blocks (F0 .. F7) and dropped stray bytes are handled
// inside; bytes that do not complete a message produce no result.
// Flow: the byte that completes a message is written to the request queue,
// popped by the buffer, which enters its drain state, and the first byte of the
// message is then registered on the output; the rest follow one per cycle while
// out_pop is high. Throughput: one input byte per cycle while the two-entry
// request queue has room. While a message drains the buffer takes no requests;
// the queue absorbs two more bytes, after which in_full holds the sender off.
// Stalls: when out_pop stays low the drain holds, the queue fills and in_full
// rises; nothing is lost. Reset (rst_n low, synchronous) clears the stored
// status, the fill count, the queue and the result register.
module midi_message_assembler
  import mma_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_midi_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_message_byte,
  output logic       out_last_of_message
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign in_full = q_full;

  mma_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_midi_byte (in_midi_byte),
    .q_full       (q_full),
    .cmd_push     (cmd_push),
    .cmd          (front_cmd)
  );

  mma_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (back_cmd),
    .empty    (q_empty)
  );

  mma_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (back_cmd),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_message_byte    (out_message_byte),
    .out_last_of_message (out_last_of_message)
  );

endmodule
